>>> rtl/enfa_pkg.sv
package enfa_pkg;

   localparam int MAX_STATES  = 16;
   localparam int MAX_SYMBOLS = 8;

   localparam int STATE_W    = $clog2(MAX_STATES);
   localparam int SYM_W      = $clog2(MAX_SYMBOLS);
   localparam int SET_W      = MAX_STATES;
   localparam int SCNT_W     = $clog2(MAX_STATES + 1);
   localparam int YCNT_W     = $clog2(MAX_SYMBOLS + 1);
   localparam int EDGE_DEPTH = MAX_STATES * MAX_SYMBOLS;
   localparam int EDGE_AW    = STATE_W + SYM_W;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 2;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic CSR_STATE_COUNT  = 1'b0;
   localparam logic CSR_SYMBOL_COUNT = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_STATUS  = 2'd0,
      KIND_CLOSURE = 2'd1,
      KIND_SET     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_CLOS,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic               emit;
      kind_type           kind;
      logic               err;
      logic               last;
      logic [SYM_W-1:0]   rsp_sym;
      logic               clear;
      logic               eps_write;
      logic               add_rd;
      logic               add_wr;
      logic               cur_load_src;
      logic               clos_step;
      logic               base_save;
      logic               reach_clear;
      logic               scan_rd;
      logic [STATE_W-1:0] scan_state;
      logic [SYM_W-1:0]   scan_sym;
      logic               load_reach;
   } enfa_cmd_type;

   typedef struct packed {
      logic add_bad;
      logic query_bad;
      logic clos_done;
   } enfa_stat_type;

   // One bit per state below n.
   function automatic logic [SET_W-1:0] live_mask(input logic [SCNT_W-1:0] n);
      logic [SET_W-1:0] m;
      for (int i = 0; i < SET_W; i++) begin
         m[i] = (SCNT_W'(i) < n);
      end
      return m;
   endfunction

endpackage

>>> rtl/enfa_ram.sv
module enfa_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 128,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/enfa_dp.sv
module enfa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [enfa_pkg::STATE_W-1:0]  req_state_index,
   input  logic [enfa_pkg::SYM_W-1:0]    req_symbol,
   input  logic                          req_is_epsilon,
   input  logic [enfa_pkg::STATE_W-1:0]  req_target_state,
   input  logic [enfa_pkg::SCNT_W-1:0]   n_eff,
   input  logic [enfa_pkg::YCNT_W-1:0]   m_eff,
   input  enfa_pkg::enfa_cmd_type        cmd,
   output enfa_pkg::enfa_stat_type       stat,
   output logic                          rsp_valid,
   output logic [enfa_pkg::KIND_W-1:0]   rsp_kind,
   output logic [enfa_pkg::SYM_W-1:0]    rsp_result_symbol,
   output logic [enfa_pkg::SET_W-1:0]    rsp_state_set,
   output logic                          rsp_error,
   output logic                          rsp_last
);

   import enfa_pkg::*;

   logic [SET_W-1:0]      eps_ff [MAX_STATES];
   logic [EDGE_DEPTH-1:0] valid_ff;
   logic [SET_W-1:0]      cur_ff;
   logic [SET_W-1:0]      base_ff;
   logic [SET_W-1:0]      reach_ff;
   logic                  take_ff;
   logic                  rd_valid_ff;
   logic [EDGE_AW-1:0]    wr_addr_ff;
   logic [STATE_W-1:0]    dst_ff;

   logic                  rsp_valid_ff;
   kind_type              kind_ff;
   logic [SYM_W-1:0]      sym_ff;
   logic [SET_W-1:0]      set_ff;
   logic                  err_ff;
   logic                  last_ff;

   logic [SET_W-1:0]      mask;
   logic [SET_W-1:0]      clos_next;
   logic [EDGE_AW-1:0]    rd_addr;
   logic [SET_W-1:0]      rd_data;
   logic [SET_W-1:0]      reach_sum;
   logic [SET_W-1:0]      wr_data;

   assign mask = live_mask(n_eff);

   // One closure step: fold in the epsilon rows of every state in the set.
   always_comb begin
      logic [SET_W-1:0] acc;
      acc = cur_ff;
      for (int i = 0; i < MAX_STATES; i++) begin
         if (cur_ff[i]) begin
            acc = acc | eps_ff[i];
         end
      end
      clos_next = acc & mask;
   end

   assign rd_addr   = cmd.add_rd ? {req_state_index, req_symbol}
                                 : {cmd.scan_state, cmd.scan_sym};
   assign reach_sum = reach_ff | ((take_ff && rd_valid_ff) ? rd_data : '0);
   assign wr_data   = (rd_valid_ff ? rd_data : '0) | (SET_W'(1) << dst_ff);

   enfa_ram #(
      .WIDTH (SET_W),
      .DEPTH (EDGE_DEPTH)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (cmd.add_wr),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.add_rd || cmd.scan_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.add_bad   = (SCNT_W'(req_state_index) >= n_eff)
                        || (SCNT_W'(req_target_state) >= n_eff)
                        || (!req_is_epsilon && (YCNT_W'(req_symbol) >= m_eff));
   assign stat.query_bad = (SCNT_W'(req_state_index) >= n_eff);
   assign stat.clos_done = (clos_next == cur_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_STATES; i++) begin
            eps_ff[i] <= '0;
         end
         valid_ff <= '0;
      end else begin
         if (cmd.eps_write) begin
            eps_ff[req_state_index] <= eps_ff[req_state_index]
                                     | (SET_W'(1) << req_target_state);
         end
         if (cmd.add_wr) begin
            valid_ff[wr_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         take_ff      <= cmd.scan_rd && base_ff[cmd.scan_state];
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
      if (cmd.add_rd) begin
         wr_addr_ff <= {req_state_index, req_symbol};
         dst_ff     <= req_target_state;
      end
      if (cmd.cur_load_src) begin
         cur_ff <= (SET_W'(1) << req_state_index) & mask;
      end else if (cmd.load_reach) begin
         cur_ff <= reach_sum & mask;
      end else if (cmd.clos_step) begin
         cur_ff <= clos_next;
      end
      if (cmd.base_save) begin
         base_ff <= cur_ff;
      end
      reach_ff <= cmd.reach_clear ? '0 : reach_sum;
      if (cmd.emit) begin
         kind_ff <= cmd.kind;
         sym_ff  <= cmd.rsp_sym;
         set_ff  <= (cmd.kind == KIND_STATUS) ? '0 : cur_ff;
         err_ff  <= cmd.err;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_result_symbol = sym_ff;
   assign rsp_state_set     = set_ff;
   assign rsp_error         = err_ff;
   assign rsp_last          = last_ff;

endmodule

>>> rtl/enfa_ctrl.sv
module enfa_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [enfa_pkg::OP_W-1:0]    req_opcode,
   input  logic                         req_is_epsilon,
   input  logic [enfa_pkg::SCNT_W-1:0]  n_eff,
   input  logic [enfa_pkg::YCNT_W-1:0]  m_eff,
   input  enfa_pkg::enfa_stat_type      stat,
   output logic                         busy,
   output enfa_pkg::enfa_cmd_type       cmd
);

   import enfa_pkg::*;

   state_type          state_ff, state_in;
   logic [STATE_W-1:0] s_ff, s_in;
   logic [SYM_W-1:0]   a_ff, a_in;
   logic               phase_ff, phase_in;
   logic               s_last;
   logic               a_last;

   assign s_last = (SCNT_W'(s_ff) + SCNT_W'(1)) == n_eff;
   assign a_last = (YCNT_W'(a_ff) + YCNT_W'(1)) == m_eff;
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         s_ff     <= '0;
         a_ff     <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s_ff     <= s_in;
         a_ff     <= a_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      s_in           = s_ff;
      a_in           = a_ff;
      phase_in       = phase_ff;
      cmd            = '0;
      cmd.rsp_sym    = '0;
      cmd.scan_state = s_ff;
      cmd.scan_sym   = a_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_opcode)
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     cmd.emit  = 1'b1;
                     cmd.kind  = KIND_STATUS;
                     cmd.last  = 1'b1;
                  end
                  OP_ADD: begin
                     cmd.emit = 1'b1;
                     cmd.kind = KIND_STATUS;
                     cmd.err  = stat.add_bad;
                     cmd.last = 1'b1;
                     if (!stat.add_bad) begin
                        if (req_is_epsilon) begin
                           cmd.eps_write = 1'b1;
                        end else begin
                           cmd.add_rd = 1'b1;
                           state_in   = ST_ADD_WR;
                        end
                     end
                  end
                  OP_QUERY: begin
                     if (stat.query_bad) begin
                        cmd.emit = 1'b1;
                        cmd.kind = KIND_STATUS;
                        cmd.err  = 1'b1;
                        cmd.last = 1'b1;
                     end else begin
                        cmd.cur_load_src = 1'b1;
                        phase_in         = 1'b0;
                        state_in         = ST_CLOS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_CLOS: begin
            if (!stat.clos_done) begin
               cmd.clos_step = 1'b1;
            end else begin
               cmd.emit        = 1'b1;
               cmd.kind        = phase_ff ? KIND_SET : KIND_CLOSURE;
               cmd.rsp_sym     = phase_ff ? a_ff : '0;
               cmd.last        = phase_ff && a_last;
               cmd.reach_clear = 1'b1;
               s_in            = '0;
               if (!phase_ff) begin
                  cmd.base_save = 1'b1;
                  a_in          = '0;
                  phase_in      = 1'b1;
                  state_in      = ST_SCAN;
               end else if (a_last) begin
                  state_in = ST_IDLE;
               end else begin
                  a_in     = a_ff + SYM_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (s_last) begin
               state_in = ST_DRAIN;
            end else begin
               s_in = s_ff + STATE_W'(1);
            end
         end
         ST_DRAIN: begin
            cmd.load_reach = 1'b1;
            state_in       = ST_CLOS;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/epsilon_nfa_to_nfa_converter.sv
// Clear and add: one status item in the cycle after start; an add of a symbol edge keeps
// busy high for the read-modify-write of the edge memory.
// Query (n states, m symbols): busy for a fixpoint closure of the source state, then for
// each of the m symbols a scan of n edge memory rows and a closure of the reached set.
// Results are strobed for one cycle and never held; the receiver cannot stall the block.
// Reset (synchronous): tables empty, state_count 16, symbol_count 8.
module epsilon_nfa_to_nfa_converter (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  logic [enfa_pkg::OP_W-1:0]     req_opcode,
   input  logic [enfa_pkg::STATE_W-1:0]  req_state_index,
   input  logic [enfa_pkg::SYM_W-1:0]    req_symbol,
   input  logic                          req_is_epsilon,
   input  logic [enfa_pkg::STATE_W-1:0]  req_target_state,
   // result channel
   output logic                          rsp_valid,
   output logic [enfa_pkg::KIND_W-1:0]   rsp_kind,
   output logic [enfa_pkg::SYM_W-1:0]    rsp_result_symbol,
   output logic [enfa_pkg::SET_W-1:0]    rsp_state_set,
   output logic                          rsp_error,
   output logic                          rsp_last,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [enfa_pkg::CSR_AW-1:0]   paddr,
   input  logic [enfa_pkg::CSR_DW-1:0]   pwdata,
   output logic [enfa_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   import enfa_pkg::*;

   logic [SCNT_W-1:0] state_count_ff;
   logic [YCNT_W-1:0] symbol_count_ff;
   logic              csr_wr;
   logic              csr_idx;
   logic [SCNT_W-1:0] n_eff;
   logic [YCNT_W-1:0] m_eff;

   enfa_cmd_type      cmd;
   enfa_stat_type     stat;

   // Register port: two word registers, index taken from the word address bit.
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_AW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff  <= SCNT_W'(MAX_STATES);
         symbol_count_ff <= YCNT_W'(MAX_SYMBOLS);
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_STATE_COUNT:  state_count_ff  <= pwdata[SCNT_W-1:0];
            CSR_SYMBOL_COUNT: symbol_count_ff <= pwdata[YCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_STATE_COUNT:  prdata = CSR_DW'(state_count_ff);
         CSR_SYMBOL_COUNT: prdata = CSR_DW'(symbol_count_ff);
         default:          prdata = '0;
      endcase
   end

   // Effective counts: zero acts as one, anything above the table size saturates.
   always_comb begin
      if (state_count_ff == '0) begin
         n_eff = SCNT_W'(1);
      end else if (state_count_ff > SCNT_W'(MAX_STATES)) begin
         n_eff = SCNT_W'(MAX_STATES);
      end else begin
         n_eff = state_count_ff;
      end
      if (symbol_count_ff == '0) begin
         m_eff = YCNT_W'(1);
      end else if (symbol_count_ff > YCNT_W'(MAX_SYMBOLS)) begin
         m_eff = YCNT_W'(MAX_SYMBOLS);
      end else begin
         m_eff = symbol_count_ff;
      end
   end

   // Sequencer: decodes each command item and walks closure and scan phases.
   enfa_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_opcode     (req_opcode),
      .req_is_epsilon (req_is_epsilon),
      .n_eff          (n_eff),
      .m_eff          (m_eff),
      .stat           (stat),
      .busy           (busy),
      .cmd            (cmd)
   );

   // Datapath: epsilon rows in flops, symbol rows in the edge memory, set registers.
   enfa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_state_index   (req_state_index),
      .req_symbol        (req_symbol),
      .req_is_epsilon    (req_is_epsilon),
      .req_target_state  (req_target_state),
      .n_eff             (n_eff),
      .m_eff             (m_eff),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_result_symbol (rsp_result_symbol),
      .rsp_state_set     (rsp_state_set),
      .rsp_error         (rsp_error),
      .rsp_last          (rsp_last)
   );

   // A status item never carries a set.
   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_STATUS) |-> (rsp_state_set == '0))
      else $error("status item carries a state set");

   // The closure item opens a query and is never its final item.
   a_closure_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_CLOSURE) |-> (!rsp_last && busy))
      else $error("closure item marked last or block idle");

   // A set item that is not final leaves the block busy with the next symbol.
   a_set_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_SET && !rsp_last) |-> busy)
      else $error("query ended before its final set item");

   // Reported sets stay within the states in use.
   a_set_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !busy && !csr_wr && !$past(csr_wr))
         |-> ((rsp_state_set & ~live_mask(n_eff)) == '0))
      else $error("state set names a state not in use");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import enfa_pkg::*;

   // Opcode three does nothing and returns nothing.
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   // Slowest query busy time plus the longest sender gap, for ~180 items.
   localparam int CYCLE_LIMIT = 400_000;
   localparam int DIR_ROWS    = 25;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [STATE_W-1:0] src;
      logic [SYM_W-1:0]   sym;
      logic               eps;
      logic [STATE_W-1:0] dst;
   } cmd_type;

   typedef struct packed {
      kind_type           rkind;
      logic [SYM_W-1:0]   rsym;
      logic [SET_W-1:0]   rset;
      logic               rerr;
      logic               rlast;
   } result_type;

   // One directed step: optional register setting applied first, then the item.
   // typed marks rows whose single result is written out here.
   typedef struct packed {
      logic               cfg;
      logic [4:0]         cfg_n;
      logic [3:0]         cfg_m;
      cmd_type            cmd;
      logic               typed;
      result_type         want;
   } row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_opcode = '0;
   logic [STATE_W-1:0]    req_state_index = '0;
   logic [SYM_W-1:0]      req_symbol = '0;
   logic                  req_is_epsilon = 1'b0;
   logic [STATE_W-1:0]    req_target_state = '0;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_kind;
   logic [SYM_W-1:0]      rsp_result_symbol;
   logic [SET_W-1:0]      rsp_state_set;
   logic                  rsp_error;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_AW-1:0]     paddr = '0;
   logic [CSR_DW-1:0]     pwdata = '0;
   logic [CSR_DW-1:0]     prdata;
   logic                  pready;

   // Shadow copy of the transition tables and the two count registers.
   logic [SET_W-1:0]      sym_targets [MAX_STATES][MAX_SYMBOLS];
   logic [SET_W-1:0]      eps_targets [MAX_STATES];
   logic [4:0]            cfg_states;
   logic [3:0]            cfg_symbols;

   result_type            pending_results [$];
   result_type            seen;
   result_type            oldest;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;

   epsilon_nfa_to_nfa_converter u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_state_index   (req_state_index),
      .req_symbol        (req_symbol),
      .req_is_epsilon    (req_is_epsilon),
      .req_target_state  (req_target_state),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_result_symbol (rsp_result_symbol),
      .rsp_state_set     (rsp_state_set),
      .rsp_error         (rsp_error),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Conversion predictor
   // ---------------------------------------------------------------------------

   // Zero means one state; anything above the table size means the full table.
   function automatic int live_states();
      if (cfg_states == 0) return 1;
      if (cfg_states > MAX_STATES) return MAX_STATES;
      return int'(cfg_states);
   endfunction

   function automatic int live_symbols();
      if (cfg_symbols == 0) return 1;
      if (cfg_symbols > MAX_SYMBOLS) return MAX_SYMBOLS;
      return int'(cfg_symbols);
   endfunction

   function automatic void clear_tables();
      for (int s = 0; s < MAX_STATES; s++) begin
         eps_targets[s] = '0;
         for (int a = 0; a < MAX_SYMBOLS; a++) sym_targets[s][a] = '0;
      end
   endfunction

   // Grow the set along epsilon moves until it stops changing; states at or
   // above n are dropped at every step, so stale edges never leak in.
   function automatic logic [SET_W-1:0] closure_set(input logic [SET_W-1:0] seed,
                                                     input int n);
      logic [SET_W-1:0] mask;
      logic [SET_W-1:0] cur;
      logic [SET_W-1:0] grown;
      mask = (n >= SET_W) ? {SET_W{1'b1}} : SET_W'((1 << n) - 1);
      cur  = seed & mask;
      for (int pass = 0; pass <= SET_W; pass++) begin
         grown = cur;
         for (int s = 0; s < n; s++) if (cur[s]) grown |= eps_targets[s];
         cur = grown & mask;
      end
      return cur;
   endfunction

   function automatic result_type mk_result(input kind_type k, input logic [SYM_W-1:0] s,
                                            input logic [SET_W-1:0] set, input logic e,
                                            input logic l);
      result_type r;
      r.rkind = k;
      r.rsym  = s;
      r.rset  = set;
      r.rerr  = e;
      r.rlast = l;
      return r;
   endfunction

   // Apply one accepted item to the shadow tables; when keep is set, queue the
   // results it should produce.
   function automatic void predict_conversion(input cmd_type c, input bit keep);
      int               n;
      int               m;
      bit               bad;
      logic [SET_W-1:0] base;
      logic [SET_W-1:0] reach;
      n = live_states();
      m = live_symbols();
      case (c.op)
         OP_CLEAR: begin
            clear_tables();
            if (keep) pending_results.push_back(mk_result(KIND_STATUS, '0, '0, 1'b0, 1'b1));
         end
         OP_ADD: begin
            // Reject out-of-range source or target, and a symbol edge past symbol_count.
            bad = (c.src >= n) || (c.dst >= n) || (!c.eps && c.sym >= m);
            if (!bad) begin
               if (c.eps) eps_targets[c.src][c.dst] = 1'b1;
               else sym_targets[c.src][c.sym][c.dst] = 1'b1;
            end
            if (keep) pending_results.push_back(mk_result(KIND_STATUS, '0, '0, bad, 1'b1));
         end
         OP_QUERY: begin
            if (!keep) begin
               // queries leave the tables alone
            end else if (c.src >= n) begin
               pending_results.push_back(mk_result(KIND_STATUS, '0, '0, 1'b1, 1'b1));
            end else begin
               base = closure_set(SET_W'(1) << c.src, n);
               pending_results.push_back(mk_result(KIND_CLOSURE, '0, base, 1'b0, 1'b0));
               for (int a = 0; a < m; a++) begin
                  // Every state of the closure contributes all of its targets.
                  reach = '0;
                  for (int s = 0; s < n; s++) if (base[s]) reach |= sym_targets[s][a];
                  pending_results.push_back(mk_result(KIND_SET, SYM_W'(a),
                                                      closure_set(reach, n), 1'b0,
                                                      a == m - 1));
               end
            end
         end
         default: begin
            // no operation, no result
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Result checker: the block cannot be stalled, so take every strobe as it comes
   // ---------------------------------------------------------------------------

   function automatic void flag_mismatch(input string what, input result_type want,
                                         input result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] %s: want kind=%0d sym=%0d set=%h err=%b last=%b", $time, what,
                  want.rkind, want.rsym, want.rset, want.rerr, want.rlast);
         $display("          got  kind=%0d sym=%0d set=%h err=%b last=%b",
                  got.rkind, got.rsym, got.rset, got.rerr, got.rlast);
      end
   endfunction

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         seen.rkind = kind_type'(rsp_kind);
         seen.rsym  = rsp_result_symbol;
         seen.rset  = rsp_state_set;
         seen.rerr  = rsp_error;
         seen.rlast = rsp_last;
         if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing outstanding", '0, seen);
         end else begin
            oldest = pending_results.pop_front();
            if (seen.rkind !== oldest.rkind || seen.rsym !== oldest.rsym ||
                seen.rset !== oldest.rset || seen.rerr !== oldest.rerr ||
                seen.rlast !== oldest.rlast)
               flag_mismatch("result mismatch", oldest, seen);
         end
      end
   end

   // Hard stop in case the block hangs or drops results.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Command driver and register access
   // ---------------------------------------------------------------------------

   // Raise start with the item and hold it until an edge sees busy low. Start is
   // left high so a back-to-back item can follow without a dead cycle.
   task automatic send_item(input cmd_type c, input bit typed, input result_type want);
      start            <= 1'b1;
      req_opcode       <= c.op;
      req_state_index  <= c.src;
      req_symbol       <= c.sym;
      req_is_epsilon   <= c.eps;
      req_target_state <= c.dst;
      do @(posedge clock); while (busy !== 1'b0);
      predict_conversion(c, !typed);
      if (typed) pending_results.push_back(want);
   endtask

   // Drop start for a stretch; a zero-length gap leaves start alone.
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop sending and wait for every outstanding result, then for the block to
   // go idle (an opcode-three item leaves no result to wait on).
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Reprogram both counts with the block idle, mirroring the register masks.
   task automatic set_config(input logic [4:0] n, input logic [3:0] m);
      wait_drained();
      write_csr({CSR_STATE_COUNT, 2'b00}, CSR_DW'(n));
      cfg_states = n;
      write_csr({CSR_SYMBOL_COUNT, 2'b00}, CSR_DW'(m));
      cfg_symbols = m;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly well-formed adds and queries within the live ranges, so closures
   // and converted sets get deep; the rest is out-of-range noise, clears and no-ops.
   function automatic cmd_type random_command();
      cmd_type c;
      int      r;
      int      n;
      int      m;
      n = live_states();
      m = live_symbols();
      r = $urandom_range(0, 99);
      c.op  = OP_ADD;
      c.src = STATE_W'($urandom_range(0, n - 1));
      c.dst = STATE_W'($urandom_range(0, n - 1));
      c.eps = ($urandom_range(0, 9) < 4);
      c.sym = c.eps ? SYM_W'($urandom_range(0, 7)) : SYM_W'($urandom_range(0, m - 1));
      if (r >= 55 && r < 80) begin
         c.op = OP_QUERY;
      end else if (r >= 80 && r < 90) begin
         c.src = STATE_W'($urandom_range(0, 15));
         c.dst = STATE_W'($urandom_range(0, 15));
         c.sym = SYM_W'($urandom_range(0, 7));
         c.eps = 1'($urandom_range(0, 1));
      end else if (r >= 90 && r < 94) begin
         c.op  = OP_QUERY;
         c.src = STATE_W'($urandom_range(0, 15));
      end else if (r >= 94 && r < 97) begin
         c.op = OP_CLEAR;
      end else if (r >= 97) begin
         c.op  = OP_NONE;
         c.src = STATE_W'($urandom_range(0, 15));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   initial begin
      row_type    directed_rows [DIR_ROWS];
      result_type st_ok;
      result_type st_bad;
      result_type no_res;
      cmd_type    c;
      int         sent;
      bit         no_idle;
      logic [4:0] n_sel;
      logic [3:0] m_sel;

      st_ok  = mk_result(KIND_STATUS, '0, '0, 1'b0, 1'b1);
      st_bad = mk_result(KIND_STATUS, '0, '0, 1'b1, 1'b1);
      no_res = '0;

      // Directed part. Rows with a typed result are plain status items; the
      // rest go through the predictor.
      directed_rows = '{
         // query straight after reset: empty tables, closure of state 0 alone
         '{1'b0, 5'd0, 4'd0, '{OP_QUERY, 4'd0,  3'd0, 1'b0, 4'd0},  1'b0, no_res},
         '{1'b0, 5'd0, 4'd0, '{OP_CLEAR, 4'd0,  3'd0, 1'b0, 4'd0},  1'b1, st_ok},
         // epsilon cycle 0 -> 1 -> 2 -> 0
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd0,  3'd0, 1'b1, 4'd1},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd1,  3'd0, 1'b1, 4'd2},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd2,  3'd0, 1'b1, 4'd0},  1'b1, st_ok},
         // symbol edges at the corners of the field ranges
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd0,  3'd0, 1'b0, 4'd15}, 1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd15, 3'd7, 1'b0, 4'd0},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd15, 3'd7, 1'b1, 4'd15}, 1'b1, st_ok},
         // edges from closure members other than the queried state
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd2,  3'd7, 1'b0, 4'd3},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd1,  3'd0, 1'b0, 4'd5},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd5,  3'd0, 1'b1, 4'd6},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_QUERY, 4'd0,  3'd0, 1'b0, 4'd0},  1'b0, no_res},
         '{1'b0, 5'd0, 4'd0, '{OP_QUERY, 4'd15, 3'd7, 1'b1, 4'd15}, 1'b0, no_res},
         // opcode three with every field at its top value: nothing comes back
         '{1'b0, 5'd0, 4'd0, '{OP_NONE,  4'd15, 3'd7, 1'b1, 4'd15}, 1'b0, no_res},
         // four states, two symbols: rejected adds and queries, one accepted add
         '{1'b1, 5'd4, 4'd2, '{OP_ADD,   4'd4,  3'd0, 1'b1, 4'd0},  1'b1, st_bad},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd0,  3'd0, 1'b1, 4'd15}, 1'b1, st_bad},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd0,  3'd2, 1'b0, 4'd1},  1'b1, st_bad},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd0,  3'd7, 1'b1, 4'd3},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_QUERY, 4'd5,  3'd0, 1'b0, 4'd0},  1'b1, st_bad},
         // shrunk state count: edges into dropped states must vanish
         '{1'b0, 5'd0, 4'd0, '{OP_QUERY, 4'd0,  3'd0, 1'b0, 4'd0},  1'b0, no_res},
         // zero in both registers acts as one state and one symbol
         '{1'b1, 5'd0, 4'd0, '{OP_QUERY, 4'd0,  3'd0, 1'b0, 4'd0},  1'b0, no_res},
         '{1'b0, 5'd0, 4'd0, '{OP_ADD,   4'd0,  3'd0, 1'b0, 4'd0},  1'b1, st_ok},
         '{1'b0, 5'd0, 4'd0, '{OP_QUERY, 4'd1,  3'd0, 1'b0, 4'd0},  1'b1, st_bad},
         // register values past the table size clamp to the full table
         '{1'b1, 5'd31, 4'd15, '{OP_QUERY, 4'd2, 3'd0, 1'b0, 4'd0}, 1'b0, no_res},
         '{1'b0, 5'd0, 4'd0, '{OP_CLEAR, 4'd0,  3'd0, 1'b0, 4'd0},  1'b1, st_ok}
      };

      cfg_states  = 5'd16;
      cfg_symbols = 4'd8;
      clear_tables();

      // Hold reset, then release it once.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg)
            set_config(directed_rows[i].cfg_n, directed_rows[i].cfg_m);
         send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
         hold_off(pick_gap());
      end

      // Random part: eight phases, each under its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               n_sel = 5'd16;
               m_sel = 4'd8;
            end
            1: begin
               n_sel = 5'd1;
               m_sel = 4'd1;
            end
            default: begin
               n_sel = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                                   : 5'($urandom_range(2, 16));
               m_sel = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(1, 8));
            end
         endcase
         set_config(n_sel, m_sel);
         // Some phases run back to back with no gaps at all.
         no_idle = (phase % 3 == 2);
         if ($urandom_range(0, 1) == 1) begin
            c = '0;
            c.op = OP_CLEAR;
            send_item(c, 1'b0, no_res);
            hold_off(no_idle ? 0 : pick_gap());
         end
         sent = 0;
         while (sent < 18) begin
            c = random_command();
            if (c.op != OP_NONE) sent++;
            // Occasionally let the block drain completely before the next item.
            if ($urandom_range(0, 19) == 0) wait_drained();
            send_item(c, 1'b0, no_res);
            hold_off(no_idle ? 0 : pick_gap());
         end
      end

      // Drain, then watch a little longer for stray results.
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> epsilon_nfa_to_nfa_converter.f
rtl/enfa_pkg.sv
rtl/enfa_ram.sv
rtl/enfa_dp.sv
rtl/enfa_ctrl.sv
rtl/epsilon_nfa_to_nfa_converter.sv
tb/sv/testbench.sv
